// File: design/tos_pkg.sv
// timed output scheduler package: word types, rule layout, codes and helpers
// no dependencies; used by timed_output_scheduler_top
package tos_pkg;

    localparam int MASK_W       = 8;
    localparam int CNT_W        = 16;
    localparam int SECS_PER_MIN = 60;

    // action codes carried in the input word
    typedef enum logic [2:0] {
        ACT_EVENT  = 3'd0,
        ACT_FORCE  = 3'd1,
        ACT_CLOCK  = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_WR_ON  = 3'd4,
        ACT_WR_OFF = 3'd5
    } action_t;

    // calendar match kinds, codes above hourly never match
    typedef enum logic [2:0] {
        KIND_YEARLY  = 3'd0,
        KIND_MONTHLY = 3'd1,
        KIND_WEEKLY  = 3'd2,
        KIND_DAILY   = 3'd3,
        KIND_HOURLY  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_ON       = 2'd1,
        MODE_ON_PEND  = 2'd2,
        MODE_OFF_PEND = 2'd3
    } mode_t;

    // rule layout, msb first, so that bit 0 of the packed word is ev_en
    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] kind;
        logic [7:0] auto_min;
        logic [7:0] ev_delay;
        logic [3:0] src;
        logic       auto_en;
        logic       cal_en;
        logic       ev_en;
    } rule_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  event_source;
        logic [2:0]  channel;
        logic        force_on;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [48:0] rule_word;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] set_mask;
        logic [MASK_W-1:0] clear_mask;
    } result_t;

    // minutes to seconds, constant multiply
    function automatic logic [CNT_W-1:0] mins_to_secs(input logic [7:0] mins);
        return CNT_W'(mins) * CNT_W'(SECS_PER_MIN);
    endfunction

    function automatic logic time_match(input rule_t r, input item_t it);
        logic mo, dy, wd, hr, mi;
        logic hit;
        mo = (r.month == it.month);
        dy = (r.day == it.day);
        wd = (r.weekday == it.weekday);
        hr = (r.hour == it.hour);
        mi = (r.minute == it.minute);
        case (r.kind)
            KIND_YEARLY:  hit = mo && dy && hr && mi;
            KIND_MONTHLY: hit = dy && hr && mi;
            KIND_WEEKLY:  hit = wd && hr && mi;
            KIND_DAILY:   hit = hr && mi;
            KIND_HOURLY:  hit = mi;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// File: design/timed_output_scheduler_top.sv
// timed output scheduler: per-channel mode and countdown, rule tables, result masks
// depends on tos_pkg for word types, codes and the calendar match helper
// a word is first held in the input register; its result is loaded into the result register once that is free
// throughput: one word per cycle while the result is not stalled, set by the single update pass over all channels
// the result register frees the input side whenever the consumer takes the result
// reset: all channels off, countdowns zero, all rules cleared, no word in flight
module timed_output_scheduler_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  tos_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output tos_pkg::result_t result
);
    import tos_pkg::*;

    // width that holds both the channel count and the 8-bit masks
    localparam int WIDE_W = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;

    // input register
    item_t held_reg;
    logic  held_valid_reg;

    // result register
    result_t result_reg;
    logic    result_valid_reg;

    // channel state and rule tables, one entry per channel
    mode_t            mode_reg [NUM_CHANNELS];
    mode_t            mode_next [NUM_CHANNELS];
    logic [CNT_W-1:0] cnt_reg [NUM_CHANNELS];
    logic [CNT_W-1:0] cnt_next [NUM_CHANNELS];
    rule_t            on_rule_reg [NUM_CHANNELS];
    rule_t            on_rule_next [NUM_CHANNELS];
    rule_t            off_rule_reg [NUM_CHANNELS];
    rule_t            off_rule_next [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0] set_bits;
    logic [NUM_CHANNELS-1:0] clear_bits;
    logic [WIDE_W-1:0]       set_wide;
    logic [WIDE_W-1:0]       clear_wide;
    result_t                 result_next;

    logic result_free;
    logic held_go;
    logic item_take;

    // result register can load when empty or being drained this cycle
    assign result_free = !result_valid_reg || !result_stall;
    assign held_go     = held_valid_reg && result_free;
    assign item_stall  = held_valid_reg && !result_free;
    assign item_take   = item_valid && !item_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // one pass over all channels in parallel
    always_comb
    begin : update_pass
        mode_t            m;
        logic             is_on;
        rule_t            r;
        rule_t            wr;
        logic             wr_hit;
        logic [CNT_W-1:0] t;
        mode_t            pend;
        mode_t            on_mode;
        logic [CNT_W-1:0] on_cnt;

        wr       = rule_t'(held_reg.rule_word);
        set_bits   = '0;
        clear_bits = '0;

        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            m     = mode_reg[c];
            is_on = (m == MODE_ON) || (m == MODE_OFF_PEND);
            r     = is_on ? off_rule_reg[c] : on_rule_reg[c];
            t     = mins_to_secs(r.ev_delay);
            pend  = is_on ? MODE_OFF_PEND : MODE_ON_PEND;
            wr_hit = (32'(held_reg.channel) == c);

            // switching on arms the auto-off delay when the off-rule enables it
            if (off_rule_reg[c].auto_en)
            begin
                on_mode = MODE_OFF_PEND;
                on_cnt  = mins_to_secs(off_rule_reg[c].auto_min);
            end
            else
            begin
                on_mode = MODE_ON;
                on_cnt  = cnt_reg[c];
            end

            mode_next[c]     = m;
            cnt_next[c]      = cnt_reg[c];
            on_rule_next[c]  = on_rule_reg[c];
            off_rule_next[c] = off_rule_reg[c];

            case (held_reg.action)
                ACT_EVENT:
                begin
                    if (r.ev_en && (r.src == held_reg.event_source))
                    begin
                        if (r.ev_delay != '0)
                        begin
                            // a running delay keeps the shorter remaining time
                            if ((m != pend) || (t < cnt_reg[c]))
                                cnt_next[c] = t;
                            mode_next[c] = pend;
                        end
                        else if (is_on)
                        begin
                            mode_next[c]  = MODE_OFF;
                            clear_bits[c] = 1'b1;
                        end
                        else
                        begin
                            mode_next[c] = on_mode;
                            cnt_next[c]  = on_cnt;
                            set_bits[c]  = 1'b1;
                        end
                    end
                end
                ACT_FORCE:
                begin
                    if (wr_hit)
                    begin
                        if (held_reg.force_on)
                        begin
                            mode_next[c] = on_mode;
                            cnt_next[c]  = on_cnt;
                            set_bits[c]  = 1'b1;
                        end
                        else
                        begin
                            mode_next[c]  = MODE_OFF;
                            clear_bits[c] = 1'b1;
                        end
                    end
                end
                ACT_CLOCK:
                begin
                    if (r.cal_en && time_match(r, held_reg))
                    begin
                        if (is_on)
                        begin
                            mode_next[c]  = MODE_OFF;
                            clear_bits[c] = 1'b1;
                        end
                        else
                        begin
                            mode_next[c] = on_mode;
                            cnt_next[c]  = on_cnt;
                            set_bits[c]  = 1'b1;
                        end
                    end
                end
                ACT_TICK:
                begin
                    if ((m == MODE_ON_PEND) || (m == MODE_OFF_PEND))
                    begin
                        if (cnt_reg[c] > CNT_W'(1))
                            cnt_next[c] = cnt_reg[c] - CNT_W'(1);
                        else if (m == MODE_OFF_PEND)
                        begin
                            // a zero count completes on this tick too
                            cnt_next[c]   = '0;
                            mode_next[c]  = MODE_OFF;
                            clear_bits[c] = 1'b1;
                        end
                        else
                        begin
                            mode_next[c] = on_mode;
                            cnt_next[c]  = off_rule_reg[c].auto_en ? on_cnt : '0;
                            set_bits[c]  = 1'b1;
                        end
                    end
                end
                ACT_WR_ON:
                begin
                    // on-rules carry no auto-off
                    if (wr_hit)
                    begin
                        on_rule_next[c]          = wr;
                        on_rule_next[c].auto_en  = 1'b0;
                        on_rule_next[c].auto_min = '0;
                    end
                end
                ACT_WR_OFF:
                begin
                    if (wr_hit)
                        off_rule_next[c] = wr;
                end
                default:
                begin
                    // unknown actions leave everything alone
                end
            endcase
        end

        // channels above the mask width drop out here
        set_wide   = WIDE_W'(set_bits);
        clear_wide = WIDE_W'(clear_bits);
        result_next.set_mask   = set_wide[MASK_W-1:0];
        result_next.clear_mask = clear_wide[MASK_W-1:0];
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
                held_valid_reg <= 1'b1;
            else if (held_go)
                held_valid_reg <= 1'b0;

            if (held_go)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
            held_reg <= item;
        if (held_go)
            result_reg <= result_next;
    end

    // channel state and rules move only when a word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                mode_reg[c]     <= MODE_OFF;
                cnt_reg[c]      <= '0;
                on_rule_reg[c]  <= '0;
                off_rule_reg[c] <= '0;
            end
        end
        else if (held_go)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                mode_reg[c]     <= mode_next[c];
                cnt_reg[c]      <= cnt_next[c];
                on_rule_reg[c]  <= on_rule_next[c];
                off_rule_reg[c] <= off_rule_next[c];
            end
        end
    end

    // a channel is never switched both ways by one word
    a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ((result_reg.set_mask & result_reg.clear_mask) == '0))
        else $error("set and clear masks overlap");

    // rule writes and unknown actions switch nothing
    a_quiet_actions: assert property (@(posedge clk) disable iff (!rst_n)
        (held_go && (held_reg.action != ACT_EVENT) && (held_reg.action != ACT_FORCE)
            && (held_reg.action != ACT_CLOCK) && (held_reg.action != ACT_TICK))
        |=> ((result_reg.set_mask == '0) && (result_reg.clear_mask == '0)))
        else $error("non-switching action reported a switch");

    // a force on a mapped channel reports exactly one channel
    a_force_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (held_go && (held_reg.action == ACT_FORCE) && (32'(held_reg.channel) < NUM_CHANNELS))
        |=> ($countones({result_reg.set_mask, result_reg.clear_mask}) == 1))
        else $error("force did not report exactly one channel");

    // input side stalls only behind a held word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (held_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled with no word waiting");

endmodule
